>>> hw/rtl/msup_pkg.sv
`default_nettype none
package msup_pkg;

    localparam int SAMPLE_DEPTH     = 256;
    localparam int SAMPLE_PERIOD_MS = 1000;
    localparam int STREAK_LIMIT     = 3;

    localparam int SMP_IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int STREAK_W  = $clog2(STREAK_LIMIT + 1);
    localparam int SMP_W     = 96;

    localparam logic [15:0] BAT_MARGIN_MV = 16'd600;
    localparam logic [15:0] RANGE_MAX_MM  = 16'd3000;
    localparam logic [13:0] MIN_MOVE_MS   = 14'd1000;
    localparam logic [9:0]  MS_PER_S      = 10'd1000;
    // ceil(2^17 / 3): exact quotient for dividends below 2^17
    localparam logic [16:0] RECIP3        = 17'd43691;
    // ceil(2^10 / 5): exact quotient for dividends below 2^10
    localparam logic [7:0]  RECIP5        = 8'd205;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_FLY   = 2'd1,
        KIND_ABORT = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_TAKEOFF = 2'd1,
        ACT_LAND    = 2'd2,
        ACT_HOLD    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FLY   = 2'd1,
        PH_ABORT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_TIMER   = 2'd1,
        END_ABORTED = 2'd2
    } t_end;

    typedef enum logic [2:0] {
        CFG_HOVER_HEIGHT = 3'd0,
        CFG_HOVER_SEC    = 3'd1,
        CFG_MIN_BATTERY  = 3'd2,
        CFG_MIN_OBSTACLE = 3'd3,
        CFG_GUARDS       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] battery_mv;
        logic [15:0] range_front;
        logic [15:0] range_back;
        logic [15:0] range_left;
        logic [15:0] range_right;
        logic [15:0] range_up;
        logic [15:0] range_down;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [1:0]  kind;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] action_ms;
        logic        can_fly;
        logic        path_clear;
        logic        flying;
        logic [1:0]  mission_phase;
        logic [14:0] peak_altitude_mm;
        logic [1:0]  end_reason;
        logic [8:0]  samples_stored;
    } t_out_item;

    typedef struct packed {
        logic [11:0] hover_height_mm;
        logic [11:0] hover_seconds;
        logic [12:0] min_battery_mv;
        logic [11:0] min_obstacle_mm;
        logic        guards_enabled;
    } t_cfg;

    typedef struct packed {
        logic                 we;
        logic [SMP_IDX_W-1:0] addr;
        logic [SMP_W-1:0]     data;
    } t_smp_wr;

    function automatic logic [11:0] clamp_range(input logic [15:0] v);
        return (v > RANGE_MAX_MM) ? 12'd0 : v[11:0];
    endfunction

    // mm to 2 cm units; a clamped range stays below 3001, so no saturation
    function automatic logic [7:0] to_2cm(input logic [11:0] mm);
        logic [9:0]  q4;
        logic [17:0] prod;
        q4   = mm[11:2];
        prod = q4 * RECIP5;
        return prod[17:10];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/msup_if.sv
`default_nettype none
interface msup_in_if;
    logic               valid;
    logic               ready;
    msup_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msup_out_if;
    logic                valid;
    logic                ready;
    msup_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msup_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/msup_sample_ram.sv
`default_nettype none
module msup_sample_ram (
    input  wire                 i_clk,
    input  msup_pkg::t_smp_wr   i_wr
);
    logic [msup_pkg::SMP_W-1:0] r_mem [msup_pkg::SAMPLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/msup_seq.sv
`default_nettype none
module msup_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  msup_pkg::t_in_item   i_item,
    input  msup_pkg::t_cfg       i_cfg,
    output msup_pkg::t_out_item  o_result,
    output msup_pkg::t_smp_wr    o_smp_wr
);
    localparam logic [msup_pkg::STREAK_W-1:0] STREAK_W_LIMIT =
        msup_pkg::STREAK_W'(msup_pkg::STREAK_LIMIT);

    logic [1:0]                    r_phase, n_phase;
    logic                          r_fly, n_fly;
    logic [31:0]                   r_climb_end, n_climb_end;
    logic [31:0]                   r_land, n_land;
    logic [31:0]                   r_last_smp, n_last_smp;
    logic [msup_pkg::STREAK_W-1:0] r_bat_streak, n_bat_streak;
    logic [msup_pkg::STREAK_W-1:0] r_obs_streak, n_obs_streak;
    logic [14:0]                   r_peak, n_peak;
    logic [1:0]                    r_end, n_end;
    logic [8:0]                    r_cnt, n_cnt;

    logic [11:0] rng [6];
    logic [15:0] hh_x10;
    logic [32:0] hh_prod;
    logic [13:0] quot, move_ms;
    logic [21:0] hover_ms;
    logic [31:0] since_smp, to_land, to_climb;
    logic        can_fly, clear, low_bat, climbed, blocked;
    logic [15:0] bat_limit;
    logic [1:0]  action;
    logic [13:0] action_ms;

    always_comb begin
        rng[0] = msup_pkg::clamp_range(i_item.range_front);
        rng[1] = msup_pkg::clamp_range(i_item.range_back);
        rng[2] = msup_pkg::clamp_range(i_item.range_left);
        rng[3] = msup_pkg::clamp_range(i_item.range_right);
        rng[4] = msup_pkg::clamp_range(i_item.range_up);
        rng[5] = msup_pkg::clamp_range(i_item.range_down);
    end

    // takeoff and landing time at 0.3 m/s, floor 1 s
    assign hh_x10   = {1'b0, i_cfg.hover_height_mm, 3'b000}
                    + {3'b000, i_cfg.hover_height_mm, 1'b0};
    assign hh_prod  = hh_x10 * msup_pkg::RECIP3;
    assign quot     = hh_prod[30:17];
    assign move_ms  = (quot < msup_pkg::MIN_MOVE_MS) ? msup_pkg::MIN_MOVE_MS : quot;
    assign hover_ms = i_cfg.hover_seconds * msup_pkg::MS_PER_S;

    assign blocked = ((rng[0] != 12'd0) && (rng[0] < i_cfg.min_obstacle_mm))
                  || ((rng[1] != 12'd0) && (rng[1] < i_cfg.min_obstacle_mm))
                  || ((rng[2] != 12'd0) && (rng[2] < i_cfg.min_obstacle_mm))
                  || ((rng[3] != 12'd0) && (rng[3] < i_cfg.min_obstacle_mm));
    assign clear   = !blocked;
    assign can_fly = i_item.battery_mv >= {3'b000, i_cfg.min_battery_mv};

    assign bat_limit = {3'b000, i_cfg.min_battery_mv} - msup_pkg::BAT_MARGIN_MV;
    assign low_bat   = ({3'b000, i_cfg.min_battery_mv} >= msup_pkg::BAT_MARGIN_MV)
                    && (i_item.battery_mv != 16'd0) && (i_item.battery_mv < bat_limit);

    assign since_smp = i_item.now_ms - r_last_smp;
    assign to_land   = i_item.now_ms - r_land;
    assign to_climb  = i_item.now_ms - r_climb_end;
    assign climbed   = !to_climb[31];

    always_comb begin
        n_phase      = r_phase;
        n_fly        = r_fly;
        n_climb_end  = r_climb_end;
        n_land       = r_land;
        n_last_smp   = r_last_smp;
        n_bat_streak = r_bat_streak;
        n_obs_streak = r_obs_streak;
        n_peak       = r_peak;
        n_end        = r_end;
        n_cnt        = r_cnt;
        action       = msup_pkg::ACT_NONE;
        action_ms    = 14'd0;
        o_smp_wr.we   = 1'b0;
        o_smp_wr.addr = '0;
        o_smp_wr.data = {i_item.pos_x, i_item.pos_y, i_item.pos_z,
                         msup_pkg::to_2cm(rng[0]), msup_pkg::to_2cm(rng[1]),
                         msup_pkg::to_2cm(rng[2]), msup_pkg::to_2cm(rng[3]),
                         msup_pkg::to_2cm(rng[4]), msup_pkg::to_2cm(rng[5])};

        case (i_item.kind)
            msup_pkg::KIND_FLY:   n_phase = msup_pkg::PH_FLY;
            msup_pkg::KIND_ABORT: n_phase = msup_pkg::PH_ABORT;
            msup_pkg::KIND_CLEAR: n_cnt   = 9'd0;
            default: ;
        endcase

        if (r_fly && (since_smp >= 32'(msup_pkg::SAMPLE_PERIOD_MS))) begin
            n_last_smp = i_item.now_ms;
            // drop samples once the store is full
            if (n_cnt < 9'(msup_pkg::SAMPLE_DEPTH)) begin
                o_smp_wr.we   = i_accept;
                o_smp_wr.addr = n_cnt[msup_pkg::SMP_IDX_W-1:0];
                n_cnt         = n_cnt + 9'd1;
            end
        end

        if ((n_phase == msup_pkg::PH_FLY) && !r_fly) begin
            if (i_cfg.guards_enabled && (!can_fly || !clear)) begin
                n_phase = msup_pkg::PH_IDLE;
            end else begin
                n_fly        = 1'b1;
                n_cnt        = 9'd0;
                n_last_smp   = i_item.now_ms;
                n_bat_streak = '0;
                n_obs_streak = '0;
                n_peak       = 15'd0;
                n_end        = msup_pkg::END_NONE;
                n_climb_end  = i_item.now_ms + 32'(move_ms);
                n_land       = i_item.now_ms + 32'(move_ms) + 32'(hover_ms);
                action       = msup_pkg::ACT_TAKEOFF;
                action_ms    = move_ms;
            end
        end else if (n_phase == msup_pkg::PH_FLY) begin
            if (!i_item.pos_z[15] && (i_item.pos_z[14:0] > r_peak)) begin
                n_peak = i_item.pos_z[14:0];
            end
            if (!to_land[31]) begin
                n_end     = msup_pkg::END_TIMER;
                action    = msup_pkg::ACT_LAND;
                action_ms = move_ms;
                n_phase   = msup_pkg::PH_IDLE;
                n_fly     = 1'b0;
            end else begin
                if (climbed) begin
                    action = msup_pkg::ACT_HOLD;
                end
                if (!i_cfg.guards_enabled || !climbed) begin
                    n_bat_streak = '0;
                    n_obs_streak = '0;
                end else begin
                    if (!low_bat) begin
                        n_bat_streak = '0;
                    end else if (r_bat_streak < STREAK_W_LIMIT) begin
                        n_bat_streak = r_bat_streak + 1'b1;
                    end
                    if (clear) begin
                        n_obs_streak = '0;
                    end else if (r_obs_streak < STREAK_W_LIMIT) begin
                        n_obs_streak = r_obs_streak + 1'b1;
                    end
                end
                if ((n_bat_streak >= STREAK_W_LIMIT) || (n_obs_streak >= STREAK_W_LIMIT)) begin
                    n_phase = msup_pkg::PH_ABORT;
                end
            end
        end else if (n_phase == msup_pkg::PH_ABORT) begin
            if (r_fly) begin
                n_end     = msup_pkg::END_ABORTED;
                action    = msup_pkg::ACT_LAND;
                action_ms = move_ms;
                n_fly     = 1'b0;
            end
            n_phase = msup_pkg::PH_IDLE;
        end
    end

    assign o_result.action           = action;
    assign o_result.action_ms        = action_ms;
    assign o_result.can_fly          = can_fly;
    assign o_result.path_clear       = clear;
    assign o_result.flying           = n_fly;
    assign o_result.mission_phase    = n_phase;
    assign o_result.peak_altitude_mm = n_peak;
    assign o_result.end_reason       = n_end;
    assign o_result.samples_stored   = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= msup_pkg::PH_IDLE;
            r_fly        <= 1'b0;
            r_climb_end  <= 32'd0;
            r_land       <= 32'd0;
            r_last_smp   <= 32'd0;
            r_bat_streak <= '0;
            r_obs_streak <= '0;
            r_peak       <= 15'd0;
            r_end        <= msup_pkg::END_NONE;
            r_cnt        <= 9'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_fly        <= n_fly;
            r_climb_end  <= n_climb_end;
            r_land       <= n_land;
            r_last_smp   <= n_last_smp;
            r_bat_streak <= n_bat_streak;
            r_obs_streak <= n_obs_streak;
            r_peak       <= n_peak;
            r_end        <= n_end;
            r_cnt        <= n_cnt;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/flight_mission_supervisor.sv
`default_nettype none
// Mission sequencer for a small hovering vehicle. Every input word is one control
// tick and yields exactly one result word carrying the action to take (takeoff or
// landing with its duration, or hold setpoint) and the phase, flying flag, peak
// altitude, end reason and sample count after that tick. The block takes one word
// per clock while its skid entry is empty: the whole tick update is combinational
// compare-and-update logic on the mission registers, and the once-a-second flight
// sample is written to a 256-entry sample memory in the same cycle. A two-entry
// output buffer lets the input take one more word while the output is stalled.
// Configuration registers are written through the configuration channel, which is
// ready whenever reset is released; write them only while no tick is in flight.
module flight_mission_supervisor (
    input  wire        i_clk,
    input  wire        i_rst_n,
    msup_in_if.sink    i_in,
    msup_out_if.source o_out,
    msup_cfg_if.sink   i_cfg
);
    msup_pkg::t_cfg      r_cfg;
    msup_pkg::t_out_item result;
    msup_pkg::t_smp_wr   smp_wr;
    msup_pkg::t_out_item r_out, r_skd;
    logic                r_out_v, r_skd_v;
    logic                accept;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && !r_skd_v;
    assign accept      = i_in.valid && i_rst_n && !r_skd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hover_height_mm <= 12'd500;
            r_cfg.hover_seconds   <= 12'd10;
            r_cfg.min_battery_mv  <= 13'd3700;
            r_cfg.min_obstacle_mm <= 12'd200;
            r_cfg.guards_enabled  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                msup_pkg::CFG_HOVER_HEIGHT: r_cfg.hover_height_mm <= i_cfg.wdata[11:0];
                msup_pkg::CFG_HOVER_SEC:    r_cfg.hover_seconds   <= i_cfg.wdata[11:0];
                msup_pkg::CFG_MIN_BATTERY:  r_cfg.min_battery_mv  <= i_cfg.wdata;
                msup_pkg::CFG_MIN_OBSTACLE: r_cfg.min_obstacle_mm <= i_cfg.wdata[11:0];
                msup_pkg::CFG_GUARDS:       r_cfg.guards_enabled  <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    msup_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in.data),
        .i_cfg    (r_cfg),
        .o_result (result),
        .o_smp_wr (smp_wr)
    );

    msup_sample_ram u_ram (
        .i_clk (i_clk),
        .i_wr  (smp_wr)
    );

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            // advance: skid word first, else the new word
            if (r_skd_v) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end else begin
                r_out_v <= accept;
            end
        end else if (accept) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            r_out <= r_skd_v ? r_skd : result;
        end else if (accept) begin
            r_skd <= result;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;

    logic i_clk;
    logic i_rst_n;

    msup_in_if  in_if ();
    msup_out_if out_if ();
    msup_cfg_if cfg_if ();

    flight_mission_supervisor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // mission predictor state, reset values
    msup_pkg::t_phase              ph           = msup_pkg::PH_IDLE;
    logic                          flying_q     = 1'b0;
    logic [31:0]                   climb_end_ms = '0;
    logic [31:0]                   land_ms      = '0;
    logic [31:0]                   last_smp_ms  = '0;
    logic [msup_pkg::STREAK_W-1:0] bat_streak   = '0;
    logic [msup_pkg::STREAK_W-1:0] obs_streak   = '0;
    logic [14:0]                   peak_mm      = '0;
    msup_pkg::t_end                end_q        = msup_pkg::END_NONE;
    logic [8:0]                    smp_count    = '0;

    // register copies seen by the predictor
    logic [11:0] cfg_hh = 12'd500;
    logic [11:0] cfg_hs = 12'd10;
    logic [12:0] cfg_mb = 13'd3700;
    logic [11:0] cfg_mo = 12'd200;
    logic        cfg_g  = 1'b0;

    // register values the stimulus plans with
    int unsigned plan_hh = 500;
    int unsigned plan_hs = 10;
    int unsigned plan_mb = 3700;
    int unsigned plan_mo = 200;

    msup_pkg::t_out_item result_q [$];
    msup_pkg::t_out_item predicted;
    logic [31:0] sim_ms   = '0;
    logic        no_idle  = 1'b0;
    logic        hold_on  = 1'b0;
    int unsigned out_wait = 0;

    int n_sent = 0, n_checked = 0, n_errors = 0, n_cycles = 0, n_cfg_writes = 0;
    int n_takeoffs = 0, n_refusals = 0, n_timer_lands = 0, n_abort_lands = 0;
    int n_holds = 0, fill_high = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, result_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("[%0t] %s", $realtime, msg);
    endtask

    function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] diff;
        diff = now - t;
        return !diff[31];
    endfunction

    function automatic logic [13:0] climb_ms();
        int unsigned ms;
        ms = (32'(cfg_hh) * 10) / 3;
        return (ms < 32'(msup_pkg::MIN_MOVE_MS)) ? msup_pkg::MIN_MOVE_MS : 14'(ms);
    endfunction

    function automatic logic [msup_pkg::STREAK_W-1:0] bump(
        input logic [msup_pkg::STREAK_W-1:0] c);
        return (c < msup_pkg::STREAK_LIMIT) ? c + 1'b1 : c;
    endfunction

    task automatic apply_config(input logic [2:0] idx, input logic [12:0] value);
        case (idx)
            msup_pkg::CFG_HOVER_HEIGHT: cfg_hh = value[11:0];
            msup_pkg::CFG_HOVER_SEC:    cfg_hs = value[11:0];
            msup_pkg::CFG_MIN_BATTERY:  cfg_mb = value;
            msup_pkg::CFG_MIN_OBSTACLE: cfg_mo = value[11:0];
            msup_pkg::CFG_GUARDS:       cfg_g  = value[0];
            default: ;
        endcase
    endtask

    // one control tick through the mission sequencer
    task automatic advance_mission(input msup_pkg::t_in_item it,
                                   output msup_pkg::t_out_item res);
        logic [15:0] raw [4];
        logic [11:0] rng;
        logic [31:0] elapsed;
        logic [13:0] dur;
        logic [1:0]  act;
        logic [13:0] act_ms;
        logic        can_fly, clear, climbed, low;
        int          i;
        raw[0] = it.range_front;
        raw[1] = it.range_back;
        raw[2] = it.range_left;
        raw[3] = it.range_right;
        act    = msup_pkg::ACT_NONE;
        act_ms = '0;
        can_fly = it.battery_mv >= cfg_mb;
        clear = 1'b1;
        for (i = 0; i < 4; i++) begin
            rng = (raw[i] > msup_pkg::RANGE_MAX_MM) ? 12'd0 : raw[i][11:0];
            if (rng != 0 && rng < cfg_mo)
                clear = 1'b0;
        end

        case (it.kind)
            msup_pkg::KIND_FLY:   ph = msup_pkg::PH_FLY;
            msup_pkg::KIND_ABORT: ph = msup_pkg::PH_ABORT;
            msup_pkg::KIND_CLEAR: smp_count = '0;
            default: ;
        endcase

        elapsed = it.now_ms - last_smp_ms;
        if (flying_q && elapsed >= 32'(msup_pkg::SAMPLE_PERIOD_MS)) begin
            last_smp_ms = it.now_ms;
            // drop the sample once the store is full
            if (smp_count < msup_pkg::SAMPLE_DEPTH)
                smp_count = smp_count + 1'b1;
        end

        if (ph == msup_pkg::PH_FLY && !flying_q) begin
            if (cfg_g && (!can_fly || !clear)) begin
                ph = msup_pkg::PH_IDLE;
                n_refusals++;
            end else begin
                dur          = climb_ms();
                flying_q     = 1'b1;
                smp_count    = '0;
                last_smp_ms  = it.now_ms;
                bat_streak   = '0;
                obs_streak   = '0;
                peak_mm      = '0;
                end_q        = msup_pkg::END_NONE;
                climb_end_ms = it.now_ms + 32'(dur);
                land_ms      = it.now_ms + 32'(dur)
                             + 32'(cfg_hs) * 32'(msup_pkg::MS_PER_S);
                act          = msup_pkg::ACT_TAKEOFF;
                act_ms       = dur;
            end
        end else if (ph == msup_pkg::PH_FLY) begin
            if (it.pos_z > 0 && it.pos_z > $signed({1'b0, peak_mm}))
                peak_mm = it.pos_z[14:0];
            if (reached(it.now_ms, land_ms)) begin
                end_q    = msup_pkg::END_TIMER;
                act      = msup_pkg::ACT_LAND;
                act_ms   = climb_ms();
                ph       = msup_pkg::PH_IDLE;
                flying_q = 1'b0;
            end else begin
                climbed = reached(it.now_ms, climb_end_ms);
                low = (cfg_mb >= msup_pkg::BAT_MARGIN_MV) && (it.battery_mv != 0) &&
                      (32'(it.battery_mv) < 32'(cfg_mb) - 32'(msup_pkg::BAT_MARGIN_MV));
                if (climbed)
                    act = msup_pkg::ACT_HOLD;
                if (!cfg_g || !climbed) begin
                    bat_streak = '0;
                    obs_streak = '0;
                end else begin
                    bat_streak = low ? bump(bat_streak) : '0;
                    obs_streak = !clear ? bump(obs_streak) : '0;
                end
                if (bat_streak >= msup_pkg::STREAK_LIMIT ||
                    obs_streak >= msup_pkg::STREAK_LIMIT)
                    ph = msup_pkg::PH_ABORT;
            end
        end else if (ph == msup_pkg::PH_ABORT) begin
            if (flying_q) begin
                end_q    = msup_pkg::END_ABORTED;
                act      = msup_pkg::ACT_LAND;
                act_ms   = climb_ms();
                flying_q = 1'b0;
            end
            ph = msup_pkg::PH_IDLE;
        end

        case (act)
            msup_pkg::ACT_TAKEOFF: n_takeoffs++;
            msup_pkg::ACT_HOLD:    n_holds++;
            msup_pkg::ACT_LAND: begin
                if (end_q == msup_pkg::END_TIMER) n_timer_lands++;
                else n_abort_lands++;
            end
            default: ;
        endcase
        if (int'(smp_count) > fill_high)
            fill_high = smp_count;

        res.action           = act;
        res.action_ms        = act_ms;
        res.can_fly          = can_fly;
        res.path_clear       = clear;
        res.flying           = flying_q;
        res.mission_phase    = ph;
        res.peak_altitude_mm = peak_mm;
        res.end_reason       = end_q;
        res.samples_stored   = smp_count;
    endtask

    task automatic check_result(input msup_pkg::t_out_item got,
                                input msup_pkg::t_out_item want);
        string tag;
        tag = $sformatf("result %0d:", n_checked);
        if (got.action !== want.action)
            report_mismatch($sformatf("%s action %0d, expected %0d", tag,
                                      got.action, want.action));
        if (got.action_ms !== want.action_ms)
            report_mismatch($sformatf("%s action_ms %0d, expected %0d", tag,
                                      got.action_ms, want.action_ms));
        if (got.can_fly !== want.can_fly)
            report_mismatch($sformatf("%s can_fly %0d, expected %0d", tag,
                                      got.can_fly, want.can_fly));
        if (got.path_clear !== want.path_clear)
            report_mismatch($sformatf("%s path_clear %0d, expected %0d", tag,
                                      got.path_clear, want.path_clear));
        if (got.flying !== want.flying)
            report_mismatch($sformatf("%s flying %0d, expected %0d", tag,
                                      got.flying, want.flying));
        if (got.mission_phase !== want.mission_phase)
            report_mismatch($sformatf("%s mission_phase %0d, expected %0d", tag,
                                      got.mission_phase, want.mission_phase));
        if (got.peak_altitude_mm !== want.peak_altitude_mm)
            report_mismatch($sformatf("%s peak_altitude_mm %0d, expected %0d", tag,
                                      got.peak_altitude_mm, want.peak_altitude_mm));
        if (got.end_reason !== want.end_reason)
            report_mismatch($sformatf("%s end_reason %0d, expected %0d", tag,
                                      got.end_reason, want.end_reason));
        if (got.samples_stored !== want.samples_stored)
            report_mismatch($sformatf("%s samples_stored %0d, expected %0d", tag,
                                      got.samples_stored, want.samples_stored));
    endtask

    // predict on every accepted input word, then retire the oldest on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                apply_config(cfg_if.index, cfg_if.wdata);
            if (in_if.valid && in_if.ready) begin
                advance_mission(in_if.data, predicted);
                result_q.push_back(predicted);
            end
            if (out_if.valid && out_if.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    check_result(out_if.data, result_q.pop_front());
                end
                n_checked++;
            end
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready)
                out_wait = no_idle ? 0 : $urandom_range(0, 6);
            if (hold_on) begin
                out_if.ready <= 1'b0;
            end else if (out_wait != 0) begin
                out_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic hold_out(input int unsigned cycles);
        hold_on <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_on <= 1'b0;
    endtask

    task automatic send_tick(input msup_pkg::t_in_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        n_sent++;
    endtask

    // drop valid and wait until every result word is back
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input msup_pkg::t_cfg_idx idx, input logic [12:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        n_cfg_writes++;
    endtask

    task automatic write_config(input int unsigned hh, input int unsigned hs,
                                input int unsigned mb, input int unsigned mo,
                                input int unsigned g);
        plan_hh = hh;
        plan_hs = hs;
        plan_mb = mb;
        plan_mo = mo;
        write_reg(msup_pkg::CFG_HOVER_HEIGHT, 13'(hh));
        write_reg(msup_pkg::CFG_HOVER_SEC, 13'(hs));
        write_reg(msup_pkg::CFG_MIN_BATTERY, 13'(mb));
        write_reg(msup_pkg::CFG_MIN_OBSTACLE, 13'(mo));
        write_reg(msup_pkg::CFG_GUARDS, 13'(g));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic msup_pkg::t_in_item base_tick(input logic [31:0] now,
                                                     input msup_pkg::t_kind k);
        msup_pkg::t_in_item it;
        it.now_ms      = now;
        it.battery_mv  = 16'd4000;
        it.range_front = 16'd1000;
        it.range_back  = 16'd1000;
        it.range_left  = 16'd1000;
        it.range_right = 16'd1000;
        it.range_up    = 16'd1000;
        it.range_down  = 16'd1000;
        it.pos_x       = '0;
        it.pos_y       = '0;
        it.pos_z       = '0;
        it.kind        = k;
        return it;
    endfunction

    function automatic logic [15:0] pick_battery(input logic sag);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'($urandom);
        if (r < 8) return 16'd0;
        if (sag || r < 18) return 16'($urandom_range(0, plan_mb));
        return 16'($urandom_range(plan_mb, plan_mb + 800));
    endfunction

    function automatic logic [15:0] pick_range();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'($urandom);
        if (r < 15) return 16'd0;
        if (r < 18) return msup_pkg::RANGE_MAX_MM;
        if (r < 20) return msup_pkg::RANGE_MAX_MM + 16'd1;
        // hover around the clearance limit
        if (r < 30) return 16'($urandom_range(0, plan_mo + 50));
        return 16'($urandom_range(plan_mo, 3000));
    endfunction

    function automatic msup_pkg::t_in_item build_tick(input msup_pkg::t_kind k,
                                                      input logic sag,
                                                      input logic obst);
        msup_pkg::t_in_item it;
        logic [15:0]        blocked;
        it.now_ms      = sim_ms;
        it.battery_mv  = pick_battery(sag);
        it.range_front = pick_range();
        it.range_back  = pick_range();
        it.range_left  = pick_range();
        it.range_right = pick_range();
        it.range_up    = pick_range();
        it.range_down  = pick_range();
        if (obst && $urandom_range(0, 9) < 8) begin
            blocked = 16'($urandom_range(1, (plan_mo > 1) ? plan_mo - 1 : 1));
            case ($urandom_range(0, 3))
                0: it.range_front = blocked;
                1: it.range_back  = blocked;
                2: it.range_left  = blocked;
                default: it.range_right = blocked;
            endcase
        end
        if ($urandom_range(0, 4) == 0) begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
        end else begin
            it.pos_x = 16'($urandom_range(0, 4000) - 2000);
            it.pos_y = 16'($urandom_range(0, 4000) - 2000);
            it.pos_z = 16'($urandom_range(0, plan_hh + 400) - 100);
        end
        it.kind = k;
        return it;
    endfunction

    task automatic step_time(input int unsigned base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) sim_ms = sim_ms + $urandom;
        else if (r < 4) sim_ms = sim_ms - $urandom_range(1, 500);
        else sim_ms = sim_ms + $urandom_range(base / 2, base + base / 2 + 1);
    endtask

    task automatic send_noise(input int unsigned n);
        msup_pkg::t_in_item it;
        repeat (n) begin
            step_time(200);
            it = build_tick(msup_pkg::t_kind'($urandom_range(0, 3)), 1'b0, 1'b0);
            it.battery_mv = 16'($urandom);
            send_tick(it);
        end
    endtask

    // takeoff, then ticks with advancing time until past the hover deadline or a tick cap
    task automatic fly_mission();
        int unsigned     dur, span, base, cap, n, elapsed, r;
        logic            sag, obst;
        msup_pkg::t_kind k;
        dur  = (plan_hh * 10) / 3;
        dur  = (dur < 1000) ? 1000 : dur;
        span = dur + plan_hs * 1000 + 1500;
        cap  = $urandom_range(20, 140);
        base = span / $urandom_range(25, 90);
        if (base == 0) base = 1;
        sag  = ($urandom_range(0, 4) == 0);
        obst = ($urandom_range(0, 4) == 0);
        step_time(base);
        send_tick(build_tick(msup_pkg::KIND_FLY, sag, obst));
        elapsed = 0;
        n = 0;
        while (elapsed < span && n < cap) begin
            step_time(base);
            elapsed += base;
            r = $urandom_range(0, 99);
            if (r < 88) k = msup_pkg::KIND_TICK;
            else if (r < 92) k = msup_pkg::KIND_FLY;
            else if (r < 95) k = msup_pkg::KIND_CLEAR;
            else k = msup_pkg::KIND_ABORT;
            send_tick(build_tick(k, sag, obst));
            n++;
        end
        if ($urandom_range(0, 1) == 0) begin
            step_time(base);
            send_tick(build_tick(msup_pkg::KIND_ABORT, sag, obst));
        end
    endtask

    task automatic test_kinds_and_extremes();
        msup_pkg::t_in_item it;
        it = base_tick(32'd0, msup_pkg::KIND_TICK);
        it.battery_mv  = '0;
        it.range_front = '0;
        it.range_back  = '0;
        it.range_left  = '0;
        it.range_right = '0;
        it.range_up    = '0;
        it.range_down  = '0;
        send_tick(it);
        it = base_tick(32'hFFFF_FFFF, msup_pkg::KIND_TICK);
        it.battery_mv  = 16'hFFFF;
        it.range_front = 16'hFFFF;
        it.range_back  = 16'hFFFF;
        it.range_left  = 16'hFFFF;
        it.range_right = 16'hFFFF;
        it.range_up    = 16'hFFFF;
        it.range_down  = 16'hFFFF;
        it.pos_x       = 16'sh7FFF;
        it.pos_y       = 16'sh7FFF;
        it.pos_z       = 16'sh7FFF;
        send_tick(it);
        // abort and clear with nothing flying
        send_tick(base_tick(32'd5, msup_pkg::KIND_ABORT));
        send_tick(base_tick(32'd10, msup_pkg::KIND_CLEAR));
        it = base_tick(32'd1000, msup_pkg::KIND_FLY);
        it.range_front = msup_pkg::RANGE_MAX_MM;
        it.range_back  = msup_pkg::RANGE_MAX_MM + 16'd1;
        it.pos_x       = 16'sh8000;
        send_tick(it);
        // fly again while already flying
        it = base_tick(32'd1100, msup_pkg::KIND_FLY);
        it.pos_z = 16'sh8000;
        send_tick(it);
        it = base_tick(32'd2700, msup_pkg::KIND_TICK);
        it.pos_z = 16'sh7FFF;
        send_tick(it);
        send_tick(base_tick(32'd2800, msup_pkg::KIND_CLEAR));
        // exactly on the hover deadline
        send_tick(base_tick(32'd12666, msup_pkg::KIND_TICK));
        // deadlines wrap past zero
        send_tick(base_tick(32'hFFFF_FF00, msup_pkg::KIND_FLY));
        send_tick(base_tick(32'h0000_0100, msup_pkg::KIND_TICK));
        send_tick(base_tick(32'h0000_0800, msup_pkg::KIND_ABORT));
        settle();
    endtask

    task automatic test_takeoff_guards();
        msup_pkg::t_in_item it;
        logic [31:0]        t;
        write_config(500, 10, 3700, 200, 1);
        it = base_tick(32'd20000, msup_pkg::KIND_FLY);
        it.battery_mv = 16'd3699;
        send_tick(it);
        it = base_tick(32'd20010, msup_pkg::KIND_FLY);
        it.battery_mv = 16'd3700;
        it.range_left = 16'd199;
        send_tick(it);
        it = base_tick(32'd20020, msup_pkg::KIND_FLY);
        it.battery_mv  = 16'd3700;
        it.range_left  = 16'd200;
        it.range_front = 16'd0;
        it.range_back  = msup_pkg::RANGE_MAX_MM + 16'd1;
        send_tick(it);
        // three low ticks after the climb raise the abort
        for (t = 22000; t < 22300; t += 100) begin
            it = base_tick(t, msup_pkg::KIND_TICK);
            it.battery_mv = 16'd3099;
            send_tick(it);
        end
        send_tick(base_tick(32'd22300, msup_pkg::KIND_TICK));
        send_tick(base_tick(32'd30000, msup_pkg::KIND_FLY));
        for (t = 32000; t < 32300; t += 100) begin
            it = base_tick(t, msup_pkg::KIND_TICK);
            it.range_right = 16'd50;
            send_tick(it);
        end
        send_tick(base_tick(32'd32300, msup_pkg::KIND_TICK));
        it = base_tick(32'd32400, msup_pkg::KIND_TICK);
        it.battery_mv = '0;
        send_tick(it);
        settle();
    endtask

    task automatic test_sample_store_full();
        int i;
        write_config(0, 400, 3000, 100, 0);
        sim_ms = 32'h7FFF_F000;
        send_tick(build_tick(msup_pkg::KIND_FLY, 1'b0, 1'b0));
        // one sample per tick, well past the store depth
        for (i = 0; i < 270; i++) begin
            sim_ms += 1000;
            send_tick(build_tick(msup_pkg::KIND_TICK, 1'b0, 1'b0));
        end
        sim_ms += 1000;
        send_tick(build_tick(msup_pkg::KIND_CLEAR, 1'b0, 1'b0));
        for (i = 0; i < 4; i++) begin
            sim_ms += 1000;
            send_tick(build_tick(msup_pkg::KIND_TICK, 1'b0, 1'b0));
        end
        sim_ms += 10;
        send_tick(build_tick(msup_pkg::KIND_ABORT, 1'b0, 1'b0));
        settle();
    endtask

    task automatic test_output_stall();
        write_config(1000, 5, 3500, 300, 1);
        no_idle = 1'b1;
        fork
            hold_out(400);
        join_none
        fly_mission();
        no_idle = 1'b0;
        settle();
    endtask

    task automatic test_random_settings();
        int unsigned setting, stop_at;
        for (setting = 0; setting < 6; setting++) begin
            case (setting)
                0: write_config(500, 10, 3700, 200, 1);
                1: write_config(0, 0, 0, 0, 1);
                2: begin
                    sim_ms = 32'hFFFE_0000;
                    write_config(4095, 3600, 5000, 3000, 1);
                end
                3: write_config(3000, 1, 599, 1, 1);
                4: write_config($urandom_range(0, 4095), $urandom_range(0, 30), 600,
                                $urandom_range(0, 3000), 1);
                default: write_config($urandom_range(0, 4095), $urandom_range(0, 30),
                                      $urandom_range(0, 5000), $urandom_range(0, 3000), 0);
            endcase
            stop_at = n_sent + 220;
            while (n_sent < stop_at) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
                else fly_mission();
            end
            no_idle = 1'b0;
            settle();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= msup_pkg::CFG_HOVER_HEIGHT;
        cfg_if.wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_kinds_and_extremes();
        test_takeoff_guards();
        test_sample_store_full();
        test_output_stall();
        test_random_settings();

        settle();
        // catch any stray word after the last expected one
        repeat (8) @(posedge i_clk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", result_q.size()));
        $display("ran %0d ticks and checked %0d results across %0d register writes",
                 n_sent, n_checked, n_cfg_writes);
        $display("saw %0d takeoffs, %0d refusals, %0d timed and %0d aborted landings,",
                 n_takeoffs, n_refusals, n_timer_lands, n_abort_lands);
        $display("%0d holds, store filled up to %0d samples", n_holds, fill_high);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
